@@ src/rne_pkg.sv @@
// ----------------------------------------------------------------------------
// Roman numeral encoder package
// Numeral table, microcode word layout and the microcode program.
// ----------------------------------------------------------------------------
package rne_pkg;

    localparam int unsigned NUM_WIDTH = 12;
    localparam logic [NUM_WIDTH-1:0] MAX_VALID = 12'd3999;

    typedef logic [NUM_WIDTH-1:0] t_num;
    typedef logic [3:0]           t_idx;
    typedef logic [9:0]           t_val;
    typedef logic [7:0]           t_char;

    localparam t_char CHAR_NONE = 8'h00;
    localparam t_char CHAR_I    = 8'h49;
    localparam t_char CHAR_V    = 8'h56;
    localparam t_char CHAR_X    = 8'h58;
    localparam t_char CHAR_L    = 8'h4C;
    localparam t_char CHAR_C    = 8'h43;
    localparam t_char CHAR_D    = 8'h44;
    localparam t_char CHAR_M    = 8'h4D;

    typedef enum logic [1:0] {
        ACT_NONE,
        ACT_LOAD,
        ACT_STEP,
        ACT_ERROR
    } t_act;

    typedef enum logic [1:0] {
        COND_ALWAYS,
        COND_START,
        COND_BAD,
        COND_LAST
    } t_cond;

    typedef enum logic [1:0] {
        UPC_IDLE,
        UPC_CHECK,
        UPC_SCAN,
        UPC_ERROR
    } t_upc;

    typedef struct packed {
        t_act  act;
        t_cond cond;
        t_upc  tgt_true;
        t_upc  tgt_false;
    } t_uword;

    // Microcode program: one control word per step.
    function automatic t_uword ucode(input t_upc upc);
        t_uword w;
        unique case (upc)
            UPC_IDLE:  w = '{act: ACT_LOAD,  cond: COND_START,
                             tgt_true: UPC_CHECK, tgt_false: UPC_IDLE};
            UPC_CHECK: w = '{act: ACT_NONE,  cond: COND_BAD,
                             tgt_true: UPC_ERROR, tgt_false: UPC_SCAN};
            UPC_SCAN:  w = '{act: ACT_STEP,  cond: COND_LAST,
                             tgt_true: UPC_IDLE,  tgt_false: UPC_SCAN};
            UPC_ERROR: w = '{act: ACT_ERROR, cond: COND_ALWAYS,
                             tgt_true: UPC_IDLE,  tgt_false: UPC_IDLE};
        endcase
        return w;
    endfunction

    function automatic t_val entry_value(input t_idx idx);
        t_val v;
        unique case (idx)
            4'd0:    v = 10'd1000;
            4'd1:    v = 10'd900;
            4'd2:    v = 10'd500;
            4'd3:    v = 10'd400;
            4'd4:    v = 10'd100;
            4'd5:    v = 10'd90;
            4'd6:    v = 10'd50;
            4'd7:    v = 10'd40;
            4'd8:    v = 10'd10;
            4'd9:    v = 10'd9;
            4'd10:   v = 10'd5;
            4'd11:   v = 10'd4;
            default: v = 10'd1;
        endcase
        return v;
    endfunction

    function automatic t_char entry_first(input t_idx idx);
        t_char c;
        unique case (idx)
            4'd0:    c = CHAR_M;
            4'd1:    c = CHAR_C;
            4'd2:    c = CHAR_D;
            4'd3:    c = CHAR_C;
            4'd4:    c = CHAR_C;
            4'd5:    c = CHAR_X;
            4'd6:    c = CHAR_L;
            4'd7:    c = CHAR_X;
            4'd8:    c = CHAR_X;
            4'd9:    c = CHAR_I;
            4'd10:   c = CHAR_V;
            4'd11:   c = CHAR_I;
            default: c = CHAR_I;
        endcase
        return c;
    endfunction

    function automatic t_char entry_second(input t_idx idx);
        t_char c;
        unique case (idx)
            4'd1:    c = CHAR_M;
            4'd3:    c = CHAR_D;
            4'd5:    c = CHAR_C;
            4'd7:    c = CHAR_L;
            4'd9:    c = CHAR_X;
            4'd11:   c = CHAR_V;
            default: c = CHAR_NONE;
        endcase
        return c;
    endfunction

    function automatic logic entry_pair(input t_idx idx);
        return (idx == 4'd1) || (idx == 4'd3) || (idx == 4'd5) ||
               (idx == 4'd7) || (idx == 4'd9) || (idx == 4'd11);
    endfunction

endpackage

@@ src/roman_numeral_encoder.sv @@
// Sequence: idle loads the number on start, check tests its range, then scan passes
// over table entries (at most 12 in all) or emits a letter; outputs are registered.
// An out-of-range number goes from check to error, which emits the error item.
// Busy is high while the sequencer is out of idle; start is taken only in idle.
// One table entry or letter per cycle.
// Reset (synchronous, active low) returns the sequencer to idle.
// The receiver cannot stall: each item appears on o_valid for one cycle.
// ----------------------------------------------------------------------------
// Roman numeral encoder
// Microcoded sequencer that emits the canonical Roman numeral of a number,
// one ASCII letter per output item, or a single error item when out of range.
// ----------------------------------------------------------------------------
module roman_numeral_encoder (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    output logic                 busy,
    input  rne_pkg::t_num        i_number,
    output logic                 o_valid,
    output rne_pkg::t_char       o_char_code,
    output logic                 o_last,
    output logic                 o_out_of_range
);

    rne_pkg::t_upc   r_upc,  n_upc;
    rne_pkg::t_num   r_rem,  n_rem;
    rne_pkg::t_idx   r_idx,  n_idx;
    logic            r_second, n_second;
    logic            n_valid, n_last, n_oor;
    rne_pkg::t_char  n_char;

    rne_pkg::t_uword uw;
    rne_pkg::t_num   val;
    logic            fit;
    logic            bad;
    logic            cond_hit;

    assign uw   = rne_pkg::ucode(r_upc);
    assign val  = {2'b00, rne_pkg::entry_value(r_idx)};
    assign fit  = (r_rem >= val);
    assign bad  = (r_rem == '0) || (r_rem > rne_pkg::MAX_VALID);
    assign busy = (r_upc != rne_pkg::UPC_IDLE);

    always_comb begin
        n_rem    = r_rem;
        n_idx    = r_idx;
        n_second = r_second;
        n_valid  = 1'b0;
        n_char   = rne_pkg::CHAR_NONE;
        n_last   = 1'b0;
        n_oor    = 1'b0;
        unique case (uw.act)
            rne_pkg::ACT_NONE: begin
            end
            rne_pkg::ACT_LOAD: begin
                n_rem    = i_number;
                n_idx    = '0;
                n_second = 1'b0;
            end
            rne_pkg::ACT_STEP: begin
                priority if (r_second) begin
                    n_valid  = 1'b1;
                    n_char   = rne_pkg::entry_second(r_idx);
                    n_rem    = r_rem - val;
                    n_last   = (r_rem == val);
                    n_second = 1'b0;
                end else if (fit) begin
                    n_valid = 1'b1;
                    n_char  = rne_pkg::entry_first(r_idx);
                    if (rne_pkg::entry_pair(r_idx)) begin
                        n_second = 1'b1;
                    end else begin
                        n_rem  = r_rem - val;
                        n_last = (r_rem == val);
                    end
                end else begin
                    n_idx = r_idx + 4'd1;
                end
            end
            rne_pkg::ACT_ERROR: begin
                n_valid = 1'b1;
                n_last  = 1'b1;
                n_oor   = 1'b1;
            end
        endcase
    end

    always_comb begin
        unique case (uw.cond)
            rne_pkg::COND_ALWAYS: cond_hit = 1'b1;
            rne_pkg::COND_START:  cond_hit = start;
            rne_pkg::COND_BAD:    cond_hit = bad;
            rne_pkg::COND_LAST:   cond_hit = n_last;
        endcase
        n_upc = cond_hit ? uw.tgt_true : uw.tgt_false;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_upc   <= rne_pkg::UPC_IDLE;
            o_valid <= 1'b0;
        end else begin
            r_upc   <= n_upc;
            o_valid <= n_valid;
        end
        r_rem          <= n_rem;
        r_idx          <= n_idx;
        r_second       <= n_second;
        o_char_code    <= n_char;
        o_last         <= n_last;
        o_out_of_range <= n_oor;
    end

`ifndef SYNTH
    a_err_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_out_of_range |-> o_last && (o_char_code == rne_pkg::CHAR_NONE))
        else $error("error item without last mark or with a letter");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy)
        else $error("accepted item did not raise busy");

    a_gap_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_last |=> !o_valid)
        else $error("item emitted right after the end of a run");

    a_idle_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) && $fell(busy) |-> o_valid && o_last)
        else $error("busy dropped without a last item");
`endif

endmodule

@@ sim/testbench.sv @@
// ----------------------------------------------------------------------------
// Roman numeral encoder testbench
// Feeds numbers to the encoder through its start/busy handshake. A predictor
// in the testbench works out the expected run of letters, or the single error
// item, for every accepted number. Each output item is then checked against
// the oldest expected item.
// ----------------------------------------------------------------------------
module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        rne_pkg::t_num number;
        int unsigned   gap;
        bit            drain;
    } t_request;

    typedef struct {
        rne_pkg::t_char code;
        logic           last;
        logic           bad;
    } t_letter;

    localparam int unsigned ROMAN_VALUE [13] =
        '{1000, 900, 500, 400, 100, 90, 50, 40, 10, 9, 5, 4, 1};
    localparam rne_pkg::t_char ROMAN_HEAD [13] =
        '{rne_pkg::CHAR_M, rne_pkg::CHAR_C, rne_pkg::CHAR_D, rne_pkg::CHAR_C,
          rne_pkg::CHAR_C, rne_pkg::CHAR_X, rne_pkg::CHAR_L, rne_pkg::CHAR_X,
          rne_pkg::CHAR_X, rne_pkg::CHAR_I, rne_pkg::CHAR_V, rne_pkg::CHAR_I,
          rne_pkg::CHAR_I};
    localparam rne_pkg::t_char ROMAN_TAIL [13] =
        '{rne_pkg::CHAR_NONE, rne_pkg::CHAR_M, rne_pkg::CHAR_NONE, rne_pkg::CHAR_D,
          rne_pkg::CHAR_NONE, rne_pkg::CHAR_C, rne_pkg::CHAR_NONE, rne_pkg::CHAR_L,
          rne_pkg::CHAR_NONE, rne_pkg::CHAR_X, rne_pkg::CHAR_NONE, rne_pkg::CHAR_V,
          rne_pkg::CHAR_NONE};

    logic           i_clk          = 1'b0;
    logic           i_rst_n        = 1'b0;
    logic           start          = 1'b0;
    rne_pkg::t_num  i_number       = '0;
    logic           busy;
    logic           o_valid;
    rne_pkg::t_char o_char_code;
    logic           o_last;
    logic           o_out_of_range;

    t_request    number_queue [$];
    t_letter     letters_due [$];
    t_request    cur_request;
    bit          loaded;
    int unsigned hold_cycles;
    bit          raise_start;
    int unsigned numbers_sent;
    int unsigned letters_seen;
    int unsigned bad_items_seen;
    int unsigned fail_count;

    roman_numeral_encoder u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_number       (i_number),
        .o_valid        (o_valid),
        .o_char_code    (o_char_code),
        .o_last         (o_last),
        .o_out_of_range (o_out_of_range)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic void queue_number(input rne_pkg::t_num number,
                                         input int unsigned gap,
                                         input bit drain);
        t_request req;
        req.number = number;
        req.gap    = gap;
        req.drain  = drain;
        number_queue.push_back(req);
    endfunction

    function automatic void predict_numeral(input rne_pkg::t_num number);
        int unsigned    rest;
        rne_pkg::t_char spelled [$];
        t_letter        item;
        rest = {20'd0, number};
        if (number == '0 || number > rne_pkg::MAX_VALID) begin
            item.code = rne_pkg::CHAR_NONE;
            item.last = 1'b1;
            item.bad  = 1'b1;
            letters_due.push_back(item);
        end else begin
            for (int t = 0; t < 13; t++) begin
                while (rest >= ROMAN_VALUE[t]) begin
                    rest -= ROMAN_VALUE[t];
                    spelled.push_back(ROMAN_HEAD[t]);
                    if (ROMAN_TAIL[t] != rne_pkg::CHAR_NONE) begin
                        spelled.push_back(ROMAN_TAIL[t]);
                    end
                end
            end
            foreach (spelled[k]) begin
                item.code = spelled[k];
                item.last = (k == spelled.size() - 1);
                item.bad  = 1'b0;
                letters_due.push_back(item);
            end
        end
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start    <= 1'b0;
            i_number <= '0;
            loaded      = 1'b0;
            hold_cycles = 0;
        end else if (!(start && busy)) begin
            if (start) begin
                predict_numeral(i_number);
                numbers_sent++;
            end
            raise_start = 1'b0;
            if (!loaded && number_queue.size() > 0) begin
                cur_request = number_queue.pop_front();
                hold_cycles = cur_request.gap;
                loaded      = 1'b1;
            end
            if (loaded) begin
                if (hold_cycles > 0) begin
                    hold_cycles--;
                end else if (!cur_request.drain || letters_due.size() == 0) begin
                    raise_start = 1'b1;
                    loaded      = 1'b0;
                end
            end
            start <= raise_start;
            if (raise_start) begin
                i_number <= cur_request.number;
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) begin
            letters_seen++;
            if (o_out_of_range) begin
                bad_items_seen++;
            end
            if (letters_due.size() == 0) begin
                $error("unexpected item: char_code %h last %b out_of_range %b",
                       o_char_code, o_last, o_out_of_range);
                fail_count++;
            end else begin
                t_letter want;
                want = letters_due.pop_front();
                if (o_char_code !== want.code) begin
                    $error("char_code: expected %h, actual %h", want.code, o_char_code);
                    fail_count++;
                end
                if (o_last !== want.last) begin
                    $error("last: expected %b, actual %b", want.last, o_last);
                    fail_count++;
                end
                if (o_out_of_range !== want.bad) begin
                    $error("out_of_range: expected %b, actual %b", want.bad, o_out_of_range);
                    fail_count++;
                end
            end
        end
    end

    initial begin
        bit            burst;
        int unsigned   pick;
        rne_pkg::t_num number;
        int unsigned   gap;

        queue_number(12'd0,    0, 1'b0);
        queue_number(12'd1,    0, 1'b0);
        queue_number(12'd3999, 3, 1'b0);
        queue_number(12'd4000, 0, 1'b0);
        queue_number(12'd4095, 1, 1'b0);
        queue_number(12'd3888, 0, 1'b0);
        queue_number(12'd4,    0, 1'b0);
        queue_number(12'd9,    2, 1'b0);
        queue_number(12'd40,   0, 1'b0);
        queue_number(12'd90,   0, 1'b0);
        queue_number(12'd400,  5, 1'b0);
        queue_number(12'd900,  0, 1'b1);
        queue_number(12'd5,    0, 1'b0);
        queue_number(12'd50,   0, 1'b0);
        queue_number(12'd500,  8, 1'b0);
        queue_number(12'd1000, 0, 1'b0);
        queue_number(12'd2048, 0, 1'b0);
        queue_number(12'd1994, 0, 1'b0);
        queue_number(12'd3,    4, 1'b0);
        queue_number(12'd444,  0, 1'b0);
        queue_number(12'd999,  0, 1'b0);
        queue_number(12'd2730, 0, 1'b0);
        queue_number(12'd1365, 0, 1'b0);

        burst = 1'b0;
        for (int n = 0; n < 330; n++) begin
            if ($urandom_range(0, 15) == 0) begin
                burst = ~burst;
            end
            pick = $urandom_range(0, 19);
            if (pick < 14) begin
                number = rne_pkg::t_num'($urandom_range(1, 3999));
            end else if (pick < 16) begin
                number = rne_pkg::t_num'($urandom_range(3000, 3999));
            end else if (pick == 16) begin
                number = rne_pkg::t_num'($urandom_range(1, 49));
            end else if (pick == 17) begin
                number = rne_pkg::t_num'($urandom_range(4000, 4095));
            end else if (pick == 18) begin
                number = '0;
            end else begin
                number = rne_pkg::t_num'($urandom_range(0, 4095));
            end
            gap = burst ? 0 : $urandom_range(0, 8);
            queue_number(number, gap, (n == 100) || ($urandom_range(0, 39) == 0));
        end

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        do @(negedge i_clk);
        while (number_queue.size() != 0 || loaded || start);
        while (letters_due.size() != 0) @(negedge i_clk);
        repeat (40) @(negedge i_clk);

        $display("Encoded %0d numbers into %0d output items, %0d of them out-of-range flags.",
                 numbers_sent, letters_seen, bad_items_seen);
        if (fail_count == 0 && letters_due.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    initial begin
        #3ms;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
